[hdl/assert_macros.svh]
// Assertion helpers used by the decoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

[hdl/ired_pkg.sv]
// ----------------------------------------------------------------------------
// ired_pkg
// Types and constants shared by the infrared edge timing frame decoder.
// ----------------------------------------------------------------------------
package ired_pkg;

  // Input request: line edge or clear command.
  typedef struct packed {
    logic        cmd;
    logic [31:0] edge_time_us;
  } in_item_t;

  // Result of one request.
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic [12:0] byte_index;
    logic [1:0]  frame_status;
    logic        decoder_reset;
    logic [1:0]  phase;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] header_min_us;
    logic [15:0] header_max_us;
    logic [15:0] gap_min_us;
    logic [14:0] bit_unit_us;
    logic [12:0] max_payload;
  } cfg_t;

  // Gap classification handed from the front end to the back end.
  typedef struct packed {
    logic force_reset;  // clear command, or zero or backward previous time
    logic gap_short;    // below gap_min_us
    logic hdr_long;     // above header_max_us
    logic hdr_short;    // below header_min_us
    logic bit_one;      // above twice the bit unit
  } gap_class_t;

  // Register indexes (byte address bits [4:2]).
  localparam logic [2:0] REG_HEADER_MIN = 3'd0;
  localparam logic [2:0] REG_HEADER_MAX = 3'd1;
  localparam logic [2:0] REG_GAP_MIN    = 3'd2;
  localparam logic [2:0] REG_BIT_UNIT   = 3'd3;
  localparam logic [2:0] REG_MAX_PAY    = 3'd4;

  // Frame status codes.
  localparam logic [1:0] FS_WAITING   = 2'd0;
  localparam logic [1:0] FS_RECEIVING = 2'd1;
  localparam logic [1:0] FS_COMPLETE  = 2'd2;
  localparam logic [1:0] FS_BAD_SIZE  = 2'd3;

  // Reported phase codes.
  localparam logic [1:0] PH_HDR_MARK   = 2'd0;
  localparam logic [1:0] PH_HDR_SPACE  = 2'd1;
  localparam logic [1:0] PH_DATA_MARK  = 2'd2;
  localparam logic [1:0] PH_DATA_SPACE = 2'd3;

  // Largest byte position the 13-bit count can reach.
  localparam int MAX_CAPACITY = 8191;

endpackage

[hdl/ired_front.sv]
// ----------------------------------------------------------------------------
// ired_front
// Accepts requests, tracks the previous edge time and classifies each gap.
// ----------------------------------------------------------------------------
module ired_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ired_pkg::in_item_t   in_data,
  input  ired_pkg::cfg_t       cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output ired_pkg::gap_class_t q_data
);

  logic [31:0] last_edge_r;
  logic [31:0] last_edge_nxt;
  logic [32:0] sub;
  logic [31:0] diff;
  logic        backward;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign sub      = {1'b0, in_data.edge_time_us} - {1'b0, last_edge_r};
  assign diff     = sub[31:0];
  // A zero previous time means no edge seen yet.
  assign backward = sub[32] || (last_edge_r == 32'd0);

  always_comb begin
    q_data.force_reset = in_data.cmd || backward;
    q_data.gap_short   = diff < {16'd0, cfg.gap_min_us};
    q_data.hdr_long    = diff > {16'd0, cfg.header_max_us};
    q_data.hdr_short   = diff < {16'd0, cfg.header_min_us};
    q_data.bit_one     = diff > {16'd0, cfg.bit_unit_us, 1'b0};
  end

  always_comb begin
    last_edge_nxt = last_edge_r;
    if (q_push && !in_data.cmd) begin
      last_edge_nxt = in_data.edge_time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= 32'd0;
    end else begin
      last_edge_r <= last_edge_nxt;
    end
  end

endmodule

[hdl/ired_queue.sv]
// ----------------------------------------------------------------------------
// ired_queue
// Two-entry queue of classified gaps between the front and back ends.
// ----------------------------------------------------------------------------
module ired_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ired_pkg::gap_class_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output ired_pkg::gap_class_t pop_data
);

  ired_pkg::gap_class_t entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[hdl/ired_back.sv]
// ----------------------------------------------------------------------------
// ired_back
// Phase machine, bit packing, frame bookkeeping and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ired_back #(
  parameter int BUF_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ired_pkg::gap_class_t q_data,
  output logic                 q_pop,
  input  ired_pkg::cfg_t       cfg,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ired_pkg::out_item_t  out_data
);

  localparam logic [12:0] CAP_BYTES =
    13'((BUF_BYTES > ired_pkg::MAX_CAPACITY) ? ired_pkg::MAX_CAPACITY : BUF_BYTES);

  typedef enum logic [3:0] {
    ST_HDR_MARK   = 4'b0001,
    ST_HDR_SPACE  = 4'b0010,
    ST_DATA_MARK  = 4'b0100,
    ST_DATA_SPACE = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  bit_shift_r, bit_shift_nxt;
  logic [2:0]  bit_count_r, bit_count_nxt;
  logic [12:0] bytes_r, bytes_nxt;
  logic [7:0]  blocks_r, blocks_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  ired_pkg::out_item_t out_data_r, res;

  logic        in_header;
  logic        dec_rst;
  logic [7:0]  new_byte;
  logic signed [15:0] total;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_header = (phase_r == ST_HDR_MARK) || (phase_r == ST_HDR_SPACE);
  assign new_byte  = {bit_shift_r, q_data.bit_one};

  always_comb begin
    phase_nxt     = phase_r;
    bit_shift_nxt = bit_shift_r;
    bit_count_nxt = bit_count_r;
    bytes_nxt     = bytes_r;
    blocks_nxt    = blocks_r;
    rem_nxt       = rem_r;
    dec_rst       = 1'b0;
    res.byte_valid = 1'b0;
    res.byte_value = 8'd0;
    res.byte_index = 13'd0;

    if (q_data.force_reset || q_data.gap_short ||
        (in_header && (q_data.hdr_long || q_data.hdr_short))) begin
      dec_rst = 1'b1;
    end else begin
      case (phase_r)
        ST_HDR_MARK:  phase_nxt = ST_HDR_SPACE;
        ST_HDR_SPACE: phase_nxt = ST_DATA_MARK;
        ST_DATA_MARK: begin
          phase_nxt = ST_DATA_SPACE;
          if (bit_count_r == 3'd7) begin
            bit_shift_nxt = 7'd0;
            bit_count_nxt = 3'd0;
            // Bytes beyond the buffer are dropped and the count holds.
            if (bytes_r < CAP_BYTES) begin
              if (bytes_r == 13'd0) begin
                blocks_nxt = new_byte;
              end
              if (bytes_r == 13'd1) begin
                rem_nxt = new_byte;
              end
              res.byte_valid = 1'b1;
              res.byte_value = new_byte;
              res.byte_index = bytes_r;
              bytes_nxt      = bytes_r + 13'd1;
            end
          end else begin
            bit_shift_nxt = {bit_shift_r[5:0], q_data.bit_one};
            bit_count_nxt = bit_count_r + 3'd1;
          end
        end
        ST_DATA_SPACE: phase_nxt = ST_DATA_MARK;
        default:       phase_nxt = ST_HDR_MARK;
      endcase
    end

    if (dec_rst) begin
      phase_nxt     = ST_HDR_MARK;
      bit_shift_nxt = 7'd0;
      bit_count_nxt = 3'd0;
      bytes_nxt     = 13'd0;
      blocks_nxt    = 8'd0;
      rem_nxt       = 8'd0;
    end
    res.decoder_reset = dec_rst;

    case (phase_nxt)
      ST_HDR_MARK:   res.phase = ired_pkg::PH_HDR_MARK;
      ST_HDR_SPACE:  res.phase = ired_pkg::PH_HDR_SPACE;
      ST_DATA_MARK:  res.phase = ired_pkg::PH_DATA_MARK;
      ST_DATA_SPACE: res.phase = ired_pkg::PH_DATA_SPACE;
      default:       res.phase = ired_pkg::PH_HDR_MARK;
    endcase

    // Frame size is (blocks - 1) * 32 + remainder, taken from the state after
    // this request.
    total = $signed({3'd0, blocks_nxt, 5'd0}) - 16'sd32 + $signed({8'd0, rem_nxt});
    if (bytes_nxt <= 13'd2) begin
      res.frame_status = ired_pkg::FS_WAITING;
    end else if ((total <= 16'sd0) || (total > $signed({3'd0, cfg.max_payload}))) begin
      res.frame_status = ired_pkg::FS_BAD_SIZE;
    end else if ($signed({3'd0, bytes_nxt}) >= (total + 16'sd2)) begin
      res.frame_status = ired_pkg::FS_COMPLETE;
    end else begin
      res.frame_status = ired_pkg::FS_RECEIVING;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_HDR_MARK;
      bit_shift_r <= 7'd0;
      bit_count_r <= 3'd0;
      bytes_r     <= 13'd0;
      blocks_r    <= 8'd0;
      rem_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        bit_shift_r <= bit_shift_nxt;
        bit_count_r <= bit_count_nxt;
        bytes_r     <= bytes_nxt;
        blocks_r    <= blocks_nxt;
        rem_r       <= rem_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_CLK(a_index_in_buf, clk, rst_n,
    !(out_valid_r && out_data_r.byte_valid) || (out_data_r.byte_index < CAP_BYTES),
    "byte index beyond buffer capacity")
  `ASSERT_CLK(a_count_capped, clk, rst_n, bytes_r <= CAP_BYTES,
    "byte count above capacity")
  `ASSERT_CLK(a_reset_result, clk, rst_n,
    !(out_valid_r && out_data_r.decoder_reset) ||
    (!out_data_r.byte_valid && (out_data_r.phase == ired_pkg::PH_HDR_MARK)),
    "decoder reset result carries a byte or a data phase")
  `ASSERT_NEXT(a_forced_clear, clk, rst_n, q_pop && q_data.force_reset,
    (bytes_r == 13'd0) && (phase_r == ST_HDR_MARK) && (bit_count_r == 3'd0),
    "clear or time reset left decoder state behind")

endmodule

[hdl/ir_edge_timing_frame_decoder.sv]
// ----------------------------------------------------------------------------
// ir_edge_timing_frame_decoder
// Infrared pulse-width decoder: turns edge timestamps into frame bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in_       input      in_valid / in_stall    ired_pkg::in_item_t
//  out_      output     out_valid / out_stall  ired_pkg::out_item_t
//  cfg_      input      APB-style, pready = 1  five registers at 4*i
//
//  One request is accepted per cycle while in_stall is low. Its gap is classified
//  and written into the queue, then the phase machine takes it and writes the
//  result register. A two-entry queue separates the two ends, so in_stall rises
//  only when it is full. Reset is synchronous and active low, and restores the
//  register defaults and the decoder state; there is no clearing pass.
// ----------------------------------------------------------------------------
module ir_edge_timing_frame_decoder #(
  parameter int BUF_BYTES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ired_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ired_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  ired_pkg::cfg_t       cfg_r, cfg_nxt;
  ired_pkg::gap_class_t push_data, pop_data;
  logic                 q_push, q_full, q_pop, q_valid;
  logic                 wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[4:2])
        ired_pkg::REG_HEADER_MIN: cfg_nxt.header_min_us = cfg_pwdata[15:0];
        ired_pkg::REG_HEADER_MAX: cfg_nxt.header_max_us = cfg_pwdata[15:0];
        ired_pkg::REG_GAP_MIN:    cfg_nxt.gap_min_us    = cfg_pwdata[15:0];
        ired_pkg::REG_BIT_UNIT:   cfg_nxt.bit_unit_us   = cfg_pwdata[14:0];
        ired_pkg::REG_MAX_PAY:    cfg_nxt.max_payload   = cfg_pwdata[12:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      ired_pkg::REG_HEADER_MIN: cfg_prdata = {16'd0, cfg_r.header_min_us};
      ired_pkg::REG_HEADER_MAX: cfg_prdata = {16'd0, cfg_r.header_max_us};
      ired_pkg::REG_GAP_MIN:    cfg_prdata = {16'd0, cfg_r.gap_min_us};
      ired_pkg::REG_BIT_UNIT:   cfg_prdata = {17'd0, cfg_r.bit_unit_us};
      ired_pkg::REG_MAX_PAY:    cfg_prdata = {19'd0, cfg_r.max_payload};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_min_us <= 16'd4000;
      cfg_r.header_max_us <= 16'd12000;
      cfg_r.gap_min_us    <= 16'd300;
      cfg_r.bit_unit_us   <= 15'd564;
      cfg_r.max_payload   <= 13'd1024;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ired_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  ired_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  ired_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sim/tb_ir_edge_timing_frame_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_edge_timing_frame_decoder
// Self-checking bench for the infrared edge timing frame decoder. Edge and
// clear requests go in through the valid/stall input channel. A cycle-free
// decoder model in the bench predicts every result, and each result from the
// output channel is checked against it. The run steps through several register
// settings and several idling mixes, and holds the output off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_ir_edge_timing_frame_decoder;

  localparam int BUF_BYTES   = 1024;
  localparam int BYTE_CAP    = (BUF_BYTES > ired_pkg::MAX_CAPACITY) ?
                               ired_pkg::MAX_CAPACITY : BUF_BYTES;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ired_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  ired_pkg::out_item_t out_data;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [4:0]          cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // Bench copy of the registers.
  logic [15:0] hdr_min_us;
  logic [15:0] hdr_max_us;
  logic [15:0] gap_min_us;
  logic [14:0] bit_unit_us;
  logic [12:0] max_payload;

  // Bench copy of the decoder state.
  logic [31:0] prev_edge_us;
  logic [1:0]  dec_phase;
  logic [6:0]  partial_bits;
  logic [2:0]  partial_count;
  logic [12:0] byte_count;
  logic [7:0]  blocks_val;
  logic [7:0]  remainder_val;

  ired_pkg::out_item_t expected_results[$];
  ired_pkg::out_item_t want;
  string       diffs;
  logic [31:0] t_now;
  logic        hold_off;
  event        start_hold;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int quiet_cycles = 0;
  int n_requests   = 0;
  int n_results    = 0;
  int n_bytes_out  = 0;
  int n_resets     = 0;
  int n_complete   = 0;
  int n_bad_size   = 0;
  int n_settings   = 0;
  int n_errors     = 0;

  ir_edge_timing_frame_decoder #(.BUF_BYTES(BUF_BYTES)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder prediction
  // --------------------------------------------------------------------------
  function automatic void restart_decoder();
    dec_phase     = ired_pkg::PH_HDR_MARK;
    partial_bits  = '0;
    partial_count = '0;
    byte_count    = '0;
    blocks_val    = '0;
    remainder_val = '0;
  endfunction

  function automatic logic [1:0] frame_state();
    int total;
    if (byte_count <= 2) return ired_pkg::FS_WAITING;
    total = (int'(blocks_val) - 1) * 32 + int'(remainder_val);
    if (total <= 0 || total > int'(max_payload)) return ired_pkg::FS_BAD_SIZE;
    if (int'(byte_count) >= total + 2) return ired_pkg::FS_COMPLETE;
    return ired_pkg::FS_RECEIVING;
  endfunction

  function automatic ired_pkg::out_item_t decode_edge(input ired_pkg::in_item_t req);
    ired_pkg::out_item_t res;
    logic [31:0] gap;
    logic        in_header;
    logic        bit_val;
    logic [7:0]  full_byte;
    res = '0;
    if (req.cmd) begin
      restart_decoder();
      res.decoder_reset = 1'b1;
    end else if (prev_edge_us == 0 || prev_edge_us > req.edge_time_us) begin
      prev_edge_us = req.edge_time_us;
      restart_decoder();
      res.decoder_reset = 1'b1;
    end else begin
      gap = req.edge_time_us - prev_edge_us;
      prev_edge_us = req.edge_time_us;
      in_header = (dec_phase == ired_pkg::PH_HDR_MARK) ||
                  (dec_phase == ired_pkg::PH_HDR_SPACE);
      if (gap < gap_min_us || (in_header && (gap > hdr_max_us || gap < hdr_min_us))) begin
        restart_decoder();
        res.decoder_reset = 1'b1;
      end else if (in_header) begin
        dec_phase = dec_phase + 2'd1;
      end else if (dec_phase == ired_pkg::PH_DATA_MARK) begin
        bit_val = (gap > {bit_unit_us, 1'b0});
        if (partial_count == 3'd7) begin
          full_byte     = {partial_bits, bit_val};
          partial_bits  = '0;
          partial_count = '0;
          // Once the buffer is full further bytes are silently dropped.
          if (int'(byte_count) < BYTE_CAP) begin
            if (byte_count == 0) blocks_val = full_byte;
            else if (byte_count == 1) remainder_val = full_byte;
            res.byte_valid = 1'b1;
            res.byte_value = full_byte;
            res.byte_index = byte_count;
            byte_count     = byte_count + 13'd1;
          end
        end else begin
          partial_bits  = {partial_bits[5:0], bit_val};
          partial_count = partial_count + 3'd1;
        end
        dec_phase = ired_pkg::PH_DATA_SPACE;
      end else begin
        dec_phase = ired_pkg::PH_DATA_MARK;
      end
    end
    res.frame_status = frame_state();
    res.phase        = dec_phase;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stall, long hold-off, result checking, watchdog
  // --------------------------------------------------------------------------
  initial begin
    hold_off <= 1'b0;
    forever begin
      @(start_hold);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  function automatic string item_text(input ired_pkg::out_item_t r);
    return $sformatf("valid=%0d byte=%02h index=%0d status=%0d reset=%0d phase=%0d",
                     r.byte_valid, r.byte_value, r.byte_index, r.frame_status,
                     r.decoder_reset, r.phase);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("Result with no request outstanding: %s", item_text(out_data));
      end else begin
        want  = expected_results.pop_front();
        diffs = "";
        if (out_data.byte_valid !== want.byte_valid) diffs = {diffs, " byte_valid"};
        if (out_data.byte_value !== want.byte_value) diffs = {diffs, " byte_value"};
        if (out_data.byte_index !== want.byte_index) diffs = {diffs, " byte_index"};
        if (out_data.frame_status !== want.frame_status) diffs = {diffs, " frame_status"};
        if (out_data.decoder_reset !== want.decoder_reset) diffs = {diffs, " decoder_reset"};
        if (out_data.phase !== want.phase) diffs = {diffs, " phase"};
        if (diffs != "") begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("Result %0d differs in%s", n_results, diffs);
            $display("  expected %s", item_text(want));
            $display("  actual   %s", item_text(out_data));
          end
        end else begin
          if (want.byte_valid) n_bytes_out++;
          if (want.decoder_reset) n_resets++;
          if (want.frame_status == ired_pkg::FS_COMPLETE) n_complete++;
          if (want.frame_status == ired_pkg::FS_BAD_SIZE) n_bad_size++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("No handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side and register access
  // --------------------------------------------------------------------------
  task automatic send_item(input ired_pkg::in_item_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(decode_edge(req));
    n_requests++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      ired_pkg::REG_HEADER_MIN: hdr_min_us  = val[15:0];
      ired_pkg::REG_HEADER_MAX: hdr_max_us  = val[15:0];
      ired_pkg::REG_GAP_MIN:    gap_min_us  = val[15:0];
      ired_pkg::REG_BIT_UNIT:   bit_unit_us = val[14:0];
      ired_pkg::REG_MAX_PAY:    max_payload = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] hmin, input logic [15:0] hmax,
                            input logic [15:0] gmin, input logic [14:0] unit,
                            input logic [12:0] maxp);
    cfg_write(ired_pkg::REG_HEADER_MIN, {16'd0, hmin});
    cfg_write(ired_pkg::REG_HEADER_MAX, {16'd0, hmax});
    cfg_write(ired_pkg::REG_GAP_MIN,    {16'd0, gmin});
    cfg_write(ired_pkg::REG_BIT_UNIT,   {17'd0, unit});
    cfg_write(ired_pkg::REG_MAX_PAY,    {19'd0, maxp});
    n_settings++;
  endtask

  function automatic longint pick(input longint lo, input longint hi);
    if (hi <= lo) return lo;
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  task automatic send_edge_at(input logic [31:0] t);
    ired_pkg::in_item_t req;
    t_now            = t;
    req.cmd          = 1'b0;
    req.edge_time_us = t;
    send_item(req);
  endtask

  task automatic send_gap(input longint gap);
    send_edge_at(t_now + gap[31:0]);
  endtask

  task automatic send_clear();
    ired_pkg::in_item_t req;
    req.cmd          = 1'b1;
    req.edge_time_us = $urandom;
    send_item(req);
  endtask

  // A mark gap carries the bit; the following space gap only has to be legal.
  task automatic send_bit(input logic b);
    longint twice;
    longint lo;
    twice = 2 * longint'(bit_unit_us);
    if (b) begin
      lo = (twice + 1 > longint'(gap_min_us)) ? twice + 1 : longint'(gap_min_us);
      send_gap(pick(lo, lo + longint'(bit_unit_us)));
    end else begin
      send_gap(pick(longint'(gap_min_us), twice));
    end
    send_gap(pick(longint'(gap_min_us), longint'(gap_min_us) + 1500));
  endtask

  task automatic send_byte(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) send_bit(b[i]);
  endtask

  task automatic send_header();
    longint lo;
    lo = (hdr_min_us > gap_min_us) ? longint'(hdr_min_us) : longint'(gap_min_us);
    send_clear();
    repeat (2) send_gap(pick(lo, longint'(hdr_max_us)));
  endtask

  // Mostly tiny single-block frames, so that complete frames are common.
  task automatic send_random_frame();
    logic [7:0] blocks;
    logic [7:0] rem;
    int         n_bytes;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 60) blocks = 8'd1;
    else if (r < 70) blocks = 8'd0;
    else if (r < 80) blocks = 8'd2;
    else blocks = 8'($urandom);
    rem     = (blocks == 8'd1) ? 8'($urandom_range(0, 8)) : 8'($urandom);
    n_bytes = (blocks == 8'd1) ? 2 + int'(rem) + int'($urandom_range(0, 2)) :
                                 int'($urandom_range(2, 6));
    send_header();
    send_byte(blocks);
    send_byte(rem);
    for (int i = 2; i < n_bytes; i++) send_byte(8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_edges();
    ired_pkg::in_item_t req;
    send_edge_at(32'd0);           // previous time zero: stored, decoder reset
    send_edge_at(32'hFFFF_FFFF);   // previous still zero, stored again
    send_edge_at(32'd5);           // time runs backwards
    send_gap(0);                   // equal time, gap below the minimum
    send_gap(100);
    send_gap(20000);               // too long for a header
    send_gap(1000);                // long enough, but too short for a header
    send_gap(4000);                // header mark at the lower bound
    send_gap(12000);               // header space at the upper bound
    send_gap(1129);                // just over twice the bit unit: one
    send_gap(300);                 // space exactly at the minimum gap
    send_gap(1128);                // exactly twice the bit unit: zero
    send_gap(65535);               // long spaces are fine in the data phase
    send_gap(299);                 // short gap in the data phase
    send_gap(4000);
    send_clear();
    req.cmd          = 1'b1;       // timestamp of a clear is ignored
    req.edge_time_us = 32'hFFFF_FFFF;
    send_item(req);
  endtask

  task automatic test_random_traffic(input int n_items);
    int start;
    int r;
    start = n_requests;
    while (n_requests - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_random_frame();
      end else if (r < 75) begin
        // Frame cut short after one to twelve bits.
        send_header();
        repeat ($urandom_range(1, 12)) send_bit(1'($urandom_range(0, 1)));
      end else if (r < 83) begin
        send_clear();
      end else if (r < 91) begin
        send_gap(longint'($urandom_range(0, 70000)));
      end else if (r < 95) begin
        send_edge_at(t_now - $urandom_range(1, 5000));
      end else if (r < 98) begin
        send_edge_at($urandom);
      end else begin
        send_edge_at(32'd0);
      end
    end
  endtask

  task automatic test_register_extremes();
    set_config(16'd0, 16'd0, 16'd0, 15'd1, 13'd1);
    test_random_traffic(110);
    wait_for_results();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 13'h1FFF);
    test_random_traffic(110);
    wait_for_results();
  endtask

  // The output is held off while requests keep coming, so the block fills up
  // and has to stall its input.
  task automatic test_output_hold_off();
    int start;
    start = n_requests;
    -> start_hold;
    while (n_requests - start < 40) send_random_frame();
  endtask

  initial begin
    int hmin_sel;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_stall   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    hdr_min_us   = 16'd4000;
    hdr_max_us   = 16'd12000;
    gap_min_us   = 16'd300;
    bit_unit_us  = 15'd564;
    max_payload  = 13'd1024;
    prev_edge_us = '0;
    t_now        = '0;
    restart_decoder();
    tx_idle_pct = 23;
    rx_idle_pct = 81;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_random_traffic(320);
    wait_for_results();

    set_config(16'd2000, 16'd9000, 16'd100, 15'd250, 13'd40);
    tx_idle_pct = 81;
    rx_idle_pct = 23;
    test_random_traffic(320);
    wait_for_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_register_extremes();

    hmin_sel = int'($urandom_range(1000, 5000));
    set_config(16'(hmin_sel), 16'(hmin_sel + int'($urandom_range(0, 8000))),
               16'($urandom_range(50, 400)), 15'($urandom_range(200, 800)),
               13'($urandom_range(1, 300)));
    test_output_hold_off();
    test_random_traffic(300);
    wait_for_results();

    $display("Covered %0d requests and %0d results over %0d register settings,",
             n_requests, n_results, n_settings + 1);
    $display("three idling mixes and a %0d-cycle hold-off: %0d bytes, %0d resets, %0d %s",
             HOLD_CYCLES, n_bytes_out, n_resets, n_complete,
             $sformatf("complete, %0d bad size.", n_bad_size));
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d results failed", n_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
